>>> rtl/hashed_timing_wheel_top_macros.svh
// Assertion macros used by the hashed timing wheel checker.
`ifndef HASHED_TIMING_WHEEL_TOP_MACROS_SVH
`define HASHED_TIMING_WHEEL_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock and idle during reset.
`define HTW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hashed timing wheel check failed");

// Next-cycle implication, sampled on clock and idle during reset.
`define HTW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hashed timing wheel check failed");

`endif

>>> rtl/htw_pkg.sv
// Package with sizes, request codes and control bundles of the hashed timing wheel.
package htw_pkg;

   localparam int WHEEL_SLOTS = 64;
   localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
   localparam int MAX_TASKS   = 16;
   localparam int TIDX_W      = $clog2(MAX_TASKS);
   localparam int ID_W        = 4;
   localparam int PERIOD_W    = 16;
   localparam int ROUNDS_W    = PERIOD_W - SLOT_W;
   localparam int REQ_W       = 2;

   // Request codes; the fourth code is ignored.
   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic add;
      logic remove;
      logic tick;
      logic scan_step;
      logic emit_final;
   } htw_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fire;
      logic pend_valid;
      logic out_free;
      logic scan_last;
   } htw_stat_type;

endpackage

>>> rtl/htw_datapath.sv
// Datapath of the hashed timing wheel: task table, wheel index, scan and result register.
module htw_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  htw_pkg::htw_cmd_type        cmd,
   output htw_pkg::htw_stat_type       stat,
   input  logic [htw_pkg::ID_W-1:0]     req_task_id,
   input  logic [htw_pkg::PERIOD_W-1:0] req_interval,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_fired,
   output logic [htw_pkg::ID_W-1:0]     rsp_fired_id,
   output logic                        rsp_last
);

   logic [htw_pkg::SLOT_W-1:0]   cur_slot_ff;
   logic [htw_pkg::MAX_TASKS-1:0] armed_ff;
   logic [htw_pkg::PERIOD_W-1:0] period_ff [htw_pkg::MAX_TASKS];
   logic [htw_pkg::SLOT_W-1:0]   slot_ff   [htw_pkg::MAX_TASKS];
   logic [htw_pkg::ROUNDS_W-1:0] rounds_ff [htw_pkg::MAX_TASKS];
   logic [htw_pkg::TIDX_W-1:0]   idx_ff;
   logic                        pend_valid_ff;
   logic [htw_pkg::TIDX_W-1:0]   pend_id_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_fired_ff;
   logic [htw_pkg::ID_W-1:0]     rsp_id_ff;
   logic                        rsp_last_ff;

   logic [htw_pkg::TIDX_W-1:0]   wr_idx;
   logic [htw_pkg::PERIOD_W-1:0] wr_src;
   logic [htw_pkg::PERIOD_W-1:0] wr_period;
   logic [htw_pkg::PERIOD_W-1:0] wr_period_m1;
   logic [htw_pkg::SLOT_W-1:0]   wr_slot;
   logic [htw_pkg::ROUNDS_W-1:0] wr_rounds;
   logic                        hit;
   logic                        fire;
   logic                        do_arm;
   logic                        load_pend;
   logic                        out_free;

   // An add arms the requested id; a firing entry re-arms itself during the scan.
   assign do_arm = cmd.add || (cmd.scan_step && fire);
   assign wr_idx = cmd.add ? req_task_id[htw_pkg::TIDX_W-1:0] : idx_ff;
   assign wr_src = cmd.add ? req_interval : period_ff[idx_ff];

   // A zero interval counts as one; slot and rounds follow from the slot count being a power of two.
   always_comb begin
      wr_period    = (wr_src == '0) ? htw_pkg::PERIOD_W'(1) : wr_src;
      wr_period_m1 = wr_period - htw_pkg::PERIOD_W'(1);
      wr_slot      = wr_period[htw_pkg::SLOT_W-1:0] + cur_slot_ff;
      wr_rounds    = wr_period_m1[htw_pkg::PERIOD_W-1:htw_pkg::SLOT_W];
   end

   // Entry under the scan index.
   assign hit  = armed_ff[idx_ff] && (slot_ff[idx_ff] == cur_slot_ff);
   assign fire = hit && (rounds_ff[idx_ff] == '0);

   // A new firing pushes the previously held one out as a non-final result.
   assign load_pend = cmd.scan_step && fire && pend_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign stat.fire       = fire;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;
   assign stat.scan_last  = (idx_ff == htw_pkg::TIDX_W'(htw_pkg::MAX_TASKS - 1));

   // Control state: wheel index, armed flags, scan index, held firing, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_slot_ff   <= '0;
         armed_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (do_arm) begin
            armed_ff[wr_idx] <= 1'b1;
         end else if (cmd.remove) begin
            armed_ff[req_task_id[htw_pkg::TIDX_W-1:0]] <= 1'b0;
         end
         if (cmd.tick) begin
            cur_slot_ff   <= cur_slot_ff + htw_pkg::SLOT_W'(1);
            idx_ff        <= '0;
            pend_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + htw_pkg::TIDX_W'(1);
            if (fire) begin
               pend_valid_ff <= 1'b1;
            end
         end else if (cmd.emit_final) begin
            pend_valid_ff <= 1'b0;
         end
         if (load_pend || cmd.emit_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Task table and held id; contents are meaningful only while armed.
   always_ff @(posedge clock) begin
      if (do_arm) begin
         period_ff[wr_idx] <= wr_period;
         slot_ff[wr_idx]   <= wr_slot;
         rounds_ff[wr_idx] <= wr_rounds;
      end else if (cmd.scan_step && hit) begin
         rounds_ff[idx_ff] <= rounds_ff[idx_ff] - htw_pkg::ROUNDS_W'(1);
      end
      if (cmd.scan_step && fire) begin
         pend_id_ff <= idx_ff;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (load_pend) begin
         rsp_fired_ff <= 1'b1;
         rsp_id_ff    <= htw_pkg::ID_W'(pend_id_ff);
         rsp_last_ff  <= 1'b0;
      end else if (cmd.emit_final) begin
         rsp_fired_ff <= pend_valid_ff;
         rsp_id_ff    <= pend_valid_ff ? htw_pkg::ID_W'(pend_id_ff) : '0;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

>>> rtl/htw_ctrl.sv
// Controller of the hashed timing wheel: request decode and the tick scan sequence.
module htw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [htw_pkg::REQ_W-1:0] req_type,
   input  htw_pkg::htw_stat_type    stat,
   output htw_pkg::htw_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINAL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      step_ok;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // A scan step waits only when it must push a held firing into a busy result register.
   assign step_ok = !(stat.fire && stat.pend_valid) || stat.out_free;

   // Command decode and next state.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  htw_pkg::REQ_ADD:    cmd.add = 1'b1;
                  htw_pkg::REQ_REMOVE: cmd.remove = 1'b1;
                  htw_pkg::REQ_TICK: begin
                     cmd.tick = 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (step_ok) begin
               cmd.scan_step = 1'b1;
               if (stat.scan_last) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (stat.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/hashed_timing_wheel_top.sv
// Add and remove leave the controller idle; the next request is taken in the following cycle.
// A tick holds off further requests while the table is scanned one entry per cycle, unless
// a held firing waits on a stalled result side, and until the final result is loaded.
// Results of a tick leave from an output register; each firing is held until a later firing
// pushes it out, and the held one goes out with the final result after the last scan step.
// Synchronous reset clears the wheel index, all armed flags and the result valid flag.
module hashed_timing_wheel_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [htw_pkg::REQ_W-1:0]    req_type,
   input  logic [htw_pkg::ID_W-1:0]     req_task_id,
   input  logic [htw_pkg::PERIOD_W-1:0] req_interval,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_fired,
   output logic [htw_pkg::ID_W-1:0]     rsp_fired_id,
   output logic                        rsp_last
);

   htw_pkg::htw_cmd_type  cmd;
   htw_pkg::htw_stat_type stat;

   // Sequencer.
   htw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Task table and result path.
   htw_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_task_id  (req_task_id),
      .req_interval (req_interval),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_fired    (rsp_fired),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last)
   );

endmodule

>>> rtl/htw_checker.sv
// Port-level checker for the hashed timing wheel, bound to the top level.
`include "hashed_timing_wheel_top_macros.svh"

module htw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [htw_pkg::REQ_W-1:0]    req_type,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_fired,
   input logic [htw_pkg::ID_W-1:0]     rsp_fired_id,
   input logic                        rsp_last
);

   // A stalled result stays offered.
   `HTW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // A result without a firing is the single final one and carries id zero.
   `HTW_ASSERT_NOW(a_idle_result, rsp_valid && !rsp_fired, rsp_last && (rsp_fired_id == '0))

   // A tick transfer starts a scan that holds off further requests.
   `HTW_ASSERT_NEXT(a_tick_busy, req_valid && !req_stall && (req_type == htw_pkg::REQ_TICK),
      req_stall)

   // A non-final result can only be shown while its tick is still being worked on.
   `HTW_ASSERT_NOW(a_partial_busy, rsp_valid && !rsp_last, req_stall)

endmodule

bind hashed_timing_wheel_top htw_checker u_htw_checker (.*);

>>> sim/hashed_timing_wheel_top_tb.sv
// Self-checking testbench for the hashed timing wheel: a table of requests, then random ones.
module hashed_timing_wheel_top_tb;

   // The fourth request code, which the wheel drops without a result.
   localparam logic [htw_pkg::REQ_W-1:0] REQ_IGNORED = 2'd3;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 205;
   localparam int STALL_PERCENT = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int STUCK_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 60;

   // One reported expiry, as it leaves the result channel.
   typedef struct packed {
      logic                     fired;
      logic [htw_pkg::ID_W-1:0] id;
      logic                     last;
   } fire_report_type;

   // One row of the directed table; a known report is typed in by hand.
   typedef struct packed {
      logic [htw_pkg::REQ_W-1:0]    kind;
      logic [htw_pkg::ID_W-1:0]     id;
      logic [htw_pkg::PERIOD_W-1:0] iv;
      logic                         known;
      fire_report_type              rep;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [htw_pkg::REQ_W-1:0]    req_type = htw_pkg::REQ_ADD;
   logic [htw_pkg::ID_W-1:0]     req_task_id = '0;
   logic [htw_pkg::PERIOD_W-1:0] req_interval = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_fired;
   logic [htw_pkg::ID_W-1:0]     rsp_fired_id;
   logic                         rsp_last;

   // While set, neither side inserts idle cycles.
   bit steady = 1'b0;

   int unsigned mismatch_count = 0;
   int unsigned stuck_cycles = 0;

   // Predicted wheel state.
   int unsigned                  wheel_index;
   logic                         ent_armed  [htw_pkg::MAX_TASKS];
   logic [htw_pkg::PERIOD_W-1:0] ent_period [htw_pkg::MAX_TASKS];
   logic [htw_pkg::SLOT_W-1:0]   ent_slot   [htw_pkg::MAX_TASKS];
   logic [htw_pkg::ROUNDS_W-1:0] ent_rounds [htw_pkg::MAX_TASKS];

   // Reports of the latest request, and all reports still owed by the wheel.
   fire_report_type tick_reports[$];
   fire_report_type due_reports[$];

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{htw_pkg::REQ_TICK,   4'd0,  16'd0,    1'b1, '{1'b0, 4'd0,  1'b1}},
      '{htw_pkg::REQ_REMOVE, 4'd3,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd15, 16'd1,    1'b0, '0},
      '{htw_pkg::REQ_TICK,   4'd0,  16'd0,    1'b1, '{1'b1, 4'd15, 1'b1}},
      '{htw_pkg::REQ_ADD,    4'd0,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_TICK,   4'd9,  16'hFFFF, 1'b0, '0},
      '{REQ_IGNORED,         4'd5,  16'hFFFF, 1'b0, '0},
      '{htw_pkg::REQ_TICK,   4'd0,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd5,  16'd64,   1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd5,  16'd2,    1'b0, '0},
      '{htw_pkg::REQ_REMOVE, 4'd15, 16'd0,    1'b0, '0},
      '{htw_pkg::REQ_REMOVE, 4'd0,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_TICK,   4'd0,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_TICK,   4'd0,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd7,  16'hFFFF, 1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd8,  16'd64,   1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd9,  16'd65,   1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd10, 16'd128,  1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd11, 16'd63,   1'b0, '0},
      '{htw_pkg::REQ_REMOVE, 4'd5,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_TICK,   4'd0,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd3,  16'hAAAA, 1'b0, '0},
      '{htw_pkg::REQ_ADD,    4'd12, 16'h5555, 1'b0, '0},
      '{htw_pkg::REQ_REMOVE, 4'd7,  16'd0,    1'b0, '0},
      '{htw_pkg::REQ_TICK,   4'd0,  16'd0,    1'b0, '0}
   };

   hashed_timing_wheel_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_task_id  (req_task_id),
      .req_interval (req_interval),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_fired    (rsp_fired),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last)
   );

   always #10 clock = ~clock;

   // Clear the predicted wheel as reset does.
   function automatic void wheel_clear();
      wheel_index = 0;
      for (int i = 0; i < htw_pkg::MAX_TASKS; i++) begin
         ent_armed[i] = 1'b0;
      end
   endfunction

   // Append one report to those of the latest request.
   function automatic void note_tick_report(fire_report_type r);
      tick_reports = {tick_reports, r};
   endfunction

   // Append one report to those the wheel still owes.
   function automatic void owe_report(fire_report_type r);
      due_reports = {due_reports, r};
   endfunction

   // Arm one entry relative to the current index; a zero period counts as one tick.
   function automatic void schedule_entry(int unsigned id,
                                          logic [htw_pkg::PERIOD_W-1:0] period);
      int unsigned p;
      p = (period == '0) ? 1 : period;
      ent_armed[id]  = 1'b1;
      ent_period[id] = htw_pkg::PERIOD_W'(p);
      ent_slot[id]   = htw_pkg::SLOT_W'((p + wheel_index) % htw_pkg::WHEEL_SLOTS);
      ent_rounds[id] = htw_pkg::ROUNDS_W'((p - 1) / htw_pkg::WHEEL_SLOTS);
   endfunction

   // Apply one request to the predicted wheel and collect the reports it causes.
   function automatic void wheel_step(logic [htw_pkg::REQ_W-1:0] kind,
                                      logic [htw_pkg::ID_W-1:0] id,
                                      logic [htw_pkg::PERIOD_W-1:0] iv);
      tick_reports.delete();
      case (kind)
         htw_pkg::REQ_ADD: begin
            if (id < htw_pkg::MAX_TASKS) schedule_entry(id, iv);
         end
         htw_pkg::REQ_REMOVE: begin
            if (id < htw_pkg::MAX_TASKS) ent_armed[id] = 1'b0;
         end
         htw_pkg::REQ_TICK: begin
            wheel_index = (wheel_index + 1) % htw_pkg::WHEEL_SLOTS;
            // Each entry is visited once per tick, so one re-armed here is not seen again in this scan.
            for (int i = 0; i < htw_pkg::MAX_TASKS; i++) begin
               if (ent_armed[i] && ent_slot[i] == htw_pkg::SLOT_W'(wheel_index)) begin
                  if (ent_rounds[i] == '0) begin
                     schedule_entry(i, ent_period[i]);
                     note_tick_report('{1'b1, htw_pkg::ID_W'(i), 1'b0});
                  end else begin
                     ent_rounds[i] = ent_rounds[i] - 1'b1;
                  end
               end
            end
            // A quiet tick still answers with one empty report.
            if (tick_reports.size() == 0) begin
               note_tick_report('{1'b0, '0, 1'b1});
            end else begin
               tick_reports[tick_reports.size() - 1].last = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   // Offer one request, wait for its transfer, then book the reports it owes.
   task automatic send_req(input logic [htw_pkg::REQ_W-1:0] kind,
                           input logic [htw_pkg::ID_W-1:0] id,
                           input logic [htw_pkg::PERIOD_W-1:0] iv, input logic known,
                           input fire_report_type rep);
      while (!steady && $urandom_range(99) < STALL_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_task_id  <= id;
      req_interval <= iv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      wheel_step(kind, id, iv);
      if (known) begin
         owe_report(rep);
      end else begin
         foreach (tick_reports[k]) owe_report(tick_reports[k]);
      end
      @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input fire_report_type want,
                                input fire_report_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display(
            "Mismatch (%s): expected fired=%0b id=%0d last=%0b, got fired=%0b id=%0d last=%0b",
            what, want.fired, want.id, want.last, got.fired, got.id, got.last);
      end
   endtask

   // The result side stalls at random, except in the steady stretch.
   always @(negedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < STALL_PERCENT);
   end

   // Compare each result transfer with the oldest owed report.
   always @(posedge clock) begin
      fire_report_type got;
      fire_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_fired, rsp_fired_id, rsp_last};
         if (due_reports.size() == 0) begin
            note_mismatch("no result owed", '0, got);
         end else begin
            want = due_reports.pop_front();
            if (got.fired != want.fired) note_mismatch("fired", want, got);
            else if (got.id != want.id) note_mismatch("fired_id", want, got);
            else if (got.last != want.last) note_mismatch("last", want, got);
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int unsigned issued;
      int unsigned pick;
      int unsigned burst_iv;
      logic [htw_pkg::PERIOD_W-1:0] iv;

      wheel_clear();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         send_req(directed_rows[n].kind, directed_rows[n].id, directed_rows[n].iv,
                  directed_rows[n].known, directed_rows[n].rep);
      end

      // Random requests, mostly short periods so that tasks fire often.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         steady = (issued >= 90 && issued < 150);
         pick = $urandom_range(99);
         if (pick < 4) begin
            // Arm every task with one period so a single tick fires them all.
            burst_iv = $urandom_range(1, 8);
            for (int j = 0; j < htw_pkg::MAX_TASKS; j++) begin
               send_req(htw_pkg::REQ_ADD, htw_pkg::ID_W'(j), htw_pkg::PERIOD_W'(burst_iv),
                        1'b0, '0);
            end
            issued += htw_pkg::MAX_TASKS;
         end else if (pick < 50) begin
            send_req(htw_pkg::REQ_TICK, htw_pkg::ID_W'($urandom),
                     htw_pkg::PERIOD_W'($urandom), 1'b0, '0);
            issued++;
         end else if (pick < 75) begin
            pick = $urandom_range(99);
            if (pick < 70) iv = htw_pkg::PERIOD_W'($urandom_range(1, 150));
            else if (pick < 90) iv = htw_pkg::PERIOD_W'($urandom_range(0, 16'hFFFF));
            else iv = htw_pkg::PERIOD_W'(htw_pkg::WHEEL_SLOTS * $urandom_range(1, 3));
            send_req(htw_pkg::REQ_ADD,
                     htw_pkg::ID_W'($urandom_range(0, htw_pkg::MAX_TASKS - 1)), iv, 1'b0, '0);
            issued++;
         end else if (pick < 92) begin
            send_req(htw_pkg::REQ_REMOVE,
                     htw_pkg::ID_W'($urandom_range(0, htw_pkg::MAX_TASKS - 1)),
                     htw_pkg::PERIOD_W'($urandom), 1'b0, '0);
            issued++;
         end else begin
            send_req(REQ_IGNORED, htw_pkg::ID_W'($urandom), htw_pkg::PERIOD_W'($urandom),
                     1'b0, '0);
            issued++;
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // Drain, then leave room for any stray result to show up.
      while (due_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> hashed_timing_wheel_top.f
+incdir+rtl
rtl/htw_pkg.sv
rtl/htw_datapath.sv
rtl/htw_ctrl.sv
rtl/hashed_timing_wheel_top.sv
rtl/htw_checker.sv
sim/hashed_timing_wheel_top_tb.sv
